### design/nls_pkg.sv
// Shared types and constants for the numeric literal scanner.
package nls_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_MAX = 255;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_NUMBER   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BIN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DEC  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAC = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_EXP  = 3'd5;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;  // 'X'
  localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;  // 'B'
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65;  // 'e'
  localparam logic [CHAR_W-1:0] CH_UC_E  = 8'h45;  // 'E'
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;  // '_'

  // character class flags, computed once in the front end
  typedef struct packed {
    logic is_zero;
    logic is_bin;
    logic is_dec;
    logic is_hex;
    logic is_x;
    logic is_b;
    logic is_dot;
    logic is_e;
    logic is_sign;
    logic is_us;
  } cls_t;

  typedef struct packed {
    logic start;
    cls_t cls;
  } q_entry_t;

  // phases that persist between characters
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_ZERO     = 8'b0000_0010,
    PH_INT      = 8'b0000_0100,
    PH_FRAC     = 8'b0000_1000,
    PH_EXP_SIGN = 8'b0001_0000,
    PH_EXP      = 8'b0010_0000,
    PH_HEX      = 8'b0100_0000,
    PH_BIN      = 8'b1000_0000
  } phase_t;

endpackage

### design/numeric_literal_scanner.sv
// Numeric literal scanner: decimal, hex and binary literal recognition, one char per request.
//
// Input channel: char_valid / char_stall with start_new and char_code. A request is
// taken on a rising edge with char_valid high and char_stall low. start_new opens a
// new literal; code 0 marks end of input and ends a literal like any other stop char.
// Output channel: result_valid / result_stall with status and length. At most one result per
// literal, issued on the request whose character cannot extend it (not counted).
// Requests after a result and before the next start produce nothing.
// Throughput: one request per cycle while char_stall is low. The front end classifies each
// character into a four-entry queue; the back end state machine retires one queue entry
// per cycle unless a stalled result holds it. An ending request is written into the queue,
// popped by the back end once it reaches the head, and its result is registered for output.
// Stall: a stalled result holds in the output register; the back end stops popping,
// the queue fills, and char_stall rises once four requests are waiting.
// Reset (rst, synchronous): queue emptied, scanner idle, no result pending.
// length saturates at MAX_LENGTH, or at 255 if MAX_LENGTH is larger, and never exceeds 255.
module numeric_literal_scanner #(
  parameter int MAX_LENGTH = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic                            start_new,
  input  logic [nls_pkg::CHAR_W-1:0]      char_code,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [nls_pkg::STATUS_W-1:0]    status,
  output logic [nls_pkg::LEN_W-1:0]       length
);

  logic push, pop, q_full, q_not_empty;
  nls_pkg::q_entry_t push_data, q_head;

  nls_front u_front (
    .char_valid (char_valid),
    .start_new  (start_new),
    .char_code  (char_code),
    .q_full     (q_full),
    .char_stall (char_stall),
    .push       (push),
    .push_data  (push_data)
  );

  nls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  nls_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .length       (length)
  );

endmodule

### design/nls_front.sv
// Front end: takes characters and classifies them into the request queue.
module nls_front (
  input  logic                         char_valid,
  input  logic                         start_new,
  input  logic [nls_pkg::CHAR_W-1:0]   char_code,
  input  logic                         q_full,
  output logic                         char_stall,
  output logic                         push,
  output nls_pkg::q_entry_t            push_data
);

  nls_pkg::cls_t cls;

  always_comb begin
    cls.is_zero = (char_code == nls_pkg::CH_ZERO);
    cls.is_bin  = (char_code == nls_pkg::CH_ZERO) || (char_code == nls_pkg::CH_ONE);
    cls.is_dec  = (char_code >= nls_pkg::CH_ZERO) && (char_code <= nls_pkg::CH_NINE);
    cls.is_hex  = cls.is_dec
                  || ((char_code >= nls_pkg::CH_LC_A) && (char_code <= nls_pkg::CH_LC_F))
                  || ((char_code >= nls_pkg::CH_UC_A) && (char_code <= nls_pkg::CH_UC_F));
    cls.is_x    = (char_code == nls_pkg::CH_LC_X) || (char_code == nls_pkg::CH_UC_X);
    cls.is_b    = (char_code == nls_pkg::CH_LC_B) || (char_code == nls_pkg::CH_UC_B);
    cls.is_dot  = (char_code == nls_pkg::CH_DOT);
    cls.is_e    = (char_code == nls_pkg::CH_LC_E) || (char_code == nls_pkg::CH_UC_E);
    cls.is_sign = (char_code == nls_pkg::CH_PLUS) || (char_code == nls_pkg::CH_MINUS);
    cls.is_us   = (char_code == nls_pkg::CH_UNDER);
  end

  assign char_stall = q_full;
  assign push = char_valid && !q_full;
  assign push_data = '{start: start_new, cls: cls};

endmodule

### design/nls_queue.sv
// Short request queue between the front end and the scanner back end.
module nls_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  nls_pkg::q_entry_t    push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output nls_pkg::q_entry_t    head
);

  nls_pkg::q_entry_t entries [nls_pkg::QUEUE_DEPTH];
  logic [nls_pkg::QPTR_W-1:0] wr_ptr;
  logic [nls_pkg::QPTR_W-1:0] rd_ptr;
  logic [nls_pkg::QCNT_W-1:0] count;

  assign full = (count == nls_pkg::QCNT_W'(nls_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= nls_pkg::QCNT_W'(nls_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### design/nls_back.sv
// Back end: literal scanning state machine, length counter and result register.
module nls_back #(
  parameter int MAX_LENGTH = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_not_empty,
  input  nls_pkg::q_entry_t               q_head,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [nls_pkg::STATUS_W-1:0]    status,
  output logic [nls_pkg::LEN_W-1:0]       length
);

  localparam int COUNT_W = $clog2(MAX_LENGTH + 1);

  nls_pkg::phase_t phase, phase_next;
  logic digit_seen, digit_seen_next;
  logic [COUNT_W-1:0] count, count_next, cur_count;
  logic consume, done;
  logic [nls_pkg::STATUS_W-1:0] status_next;
  logic [nls_pkg::LEN_W-1:0] len_sat;
  nls_pkg::cls_t c;

  assign c = q_head.cls;
  assign pop = q_not_empty && (!result_valid || !result_stall);

  always_comb begin
    cur_count = q_head.start ? '0 : count;
    consume = 1'b0;
    done = 1'b0;
    status_next = nls_pkg::ST_NUMBER;
    phase_next = phase;
    digit_seen_next = q_head.start ? 1'b0 : digit_seen;
    if (q_head.start) begin
      if (c.is_zero) begin
        consume = 1'b1;
        phase_next = nls_pkg::PH_ZERO;
      end else if (c.is_dec || c.is_us) begin
        consume = 1'b1;
        phase_next = nls_pkg::PH_INT;
        digit_seen_next = c.is_dec;
      end else begin
        done = 1'b1;
        status_next = nls_pkg::ST_BAD_DEC;
      end
    end else begin
      unique case (phase)
        nls_pkg::PH_IDLE: begin
          // waiting for a start; character dropped
        end
        nls_pkg::PH_ZERO: begin
          consume = 1'b1;
          if (c.is_x) begin
            phase_next = nls_pkg::PH_HEX;
            digit_seen_next = 1'b0;
          end else if (c.is_b) begin
            phase_next = nls_pkg::PH_BIN;
            digit_seen_next = 1'b0;
          end else if (c.is_dec) begin
            phase_next = nls_pkg::PH_INT;
            digit_seen_next = 1'b1;
          end else if (c.is_dot) begin
            phase_next = nls_pkg::PH_FRAC;
            digit_seen_next = 1'b0;
          end else if (c.is_e) begin
            phase_next = nls_pkg::PH_EXP_SIGN;
            digit_seen_next = 1'b0;
          end else begin
            consume = 1'b0;
            done = 1'b1;
          end
        end
        nls_pkg::PH_INT: begin
          if (c.is_dec || c.is_us) begin
            consume = 1'b1;
            digit_seen_next = digit_seen || c.is_dec;
          end else if (!digit_seen) begin
            done = 1'b1;
            status_next = nls_pkg::ST_BAD_DEC;
          end else if (c.is_dot) begin
            consume = 1'b1;
            phase_next = nls_pkg::PH_FRAC;
            digit_seen_next = 1'b0;
          end else if (c.is_e) begin
            consume = 1'b1;
            phase_next = nls_pkg::PH_EXP_SIGN;
            digit_seen_next = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
        nls_pkg::PH_FRAC: begin
          if (c.is_dec || c.is_us) begin
            consume = 1'b1;
            digit_seen_next = digit_seen || c.is_dec;
          end else if (!digit_seen) begin
            done = 1'b1;
            status_next = nls_pkg::ST_BAD_FRAC;
          end else if (c.is_e) begin
            consume = 1'b1;
            phase_next = nls_pkg::PH_EXP_SIGN;
            digit_seen_next = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
        nls_pkg::PH_EXP_SIGN: begin
          // sign is optional: otherwise fall into the exponent digits
          if (c.is_sign || c.is_dec || c.is_us) begin
            consume = 1'b1;
            phase_next = nls_pkg::PH_EXP;
            digit_seen_next = c.is_dec;
          end else begin
            done = 1'b1;
            status_next = nls_pkg::ST_BAD_EXP;
          end
        end
        nls_pkg::PH_EXP: begin
          if (c.is_dec || c.is_us) begin
            consume = 1'b1;
            digit_seen_next = digit_seen || c.is_dec;
          end else begin
            done = 1'b1;
            status_next = digit_seen ? nls_pkg::ST_NUMBER : nls_pkg::ST_BAD_EXP;
          end
        end
        nls_pkg::PH_HEX: begin
          if (c.is_hex || c.is_us) begin
            consume = 1'b1;
            digit_seen_next = digit_seen || c.is_hex;
          end else begin
            done = 1'b1;
            status_next = digit_seen ? nls_pkg::ST_NUMBER : nls_pkg::ST_BAD_HEX;
          end
        end
        nls_pkg::PH_BIN: begin
          if (c.is_bin || c.is_us) begin
            consume = 1'b1;
            digit_seen_next = digit_seen || c.is_bin;
          end else begin
            done = 1'b1;
            status_next = digit_seen ? nls_pkg::ST_NUMBER : nls_pkg::ST_BAD_BIN;
          end
        end
        default: begin
          phase_next = nls_pkg::PH_IDLE;
          digit_seen_next = 1'b0;
        end
      endcase
    end
    if (done) begin
      phase_next = nls_pkg::PH_IDLE;
      digit_seen_next = 1'b0;
    end
    if (consume && (cur_count < COUNT_W'(MAX_LENGTH))) begin
      count_next = cur_count + 1'b1;
    end else begin
      count_next = cur_count;
    end
  end

  // clamp the count to what the length field holds
  generate
    if (COUNT_W > nls_pkg::LEN_W) begin : g_clamp
      assign len_sat = (cur_count > COUNT_W'(nls_pkg::LEN_MAX)) ?
                       nls_pkg::LEN_W'(nls_pkg::LEN_MAX) : cur_count[nls_pkg::LEN_W-1:0];
    end else begin : g_extend
      assign len_sat = nls_pkg::LEN_W'(cur_count);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nls_pkg::PH_IDLE;
      digit_seen <= 1'b0;
      count <= '0;
    end else if (pop) begin
      phase <= phase_next;
      digit_seen <= digit_seen_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      status <= status_next;
      length <= len_sat;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && done) |=> (phase == nls_pkg::PH_IDLE))
    else $error("scanner not idle after a result");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == nls_pkg::PH_IDLE) |-> !digit_seen)
    else $error("digit flag set while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !pop)
    else $error("request taken while result is held");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= nls_pkg::ST_BAD_EXP))
    else $error("result status out of range");

endmodule

### test/tb.sv
// Testbench for numeric_literal_scanner: directed table, then random literals checked by a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int LIT_MAX = 255;

  typedef logic [nls_pkg::CHAR_W-1:0] char_t;

  typedef enum logic [3:0] {
    SC_IDLE, SC_OPEN, SC_LEAD0, SC_WHOLE, SC_POST_WHOLE, SC_FRAC, SC_POST_FRAC,
    SC_EXP_SGN, SC_EXP, SC_HEX, SC_BIN
  } scan_t;

  typedef struct packed {
    logic [nls_pkg::STATUS_W-1:0] status;
    logic [nls_pkg::LEN_W-1:0]    length;
  } lit_result_t;

  typedef struct {
    bit                           s;
    logic [nls_pkg::CHAR_W-1:0]   c;
    bit                           typed;
    logic [nls_pkg::STATUS_W-1:0] st;
    logic [nls_pkg::LEN_W-1:0]    len;
  } dir_row_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         char_valid = 1'b0;
  logic                         char_stall;
  logic                         start_new = 1'b0;
  logic [nls_pkg::CHAR_W-1:0]   char_code = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [nls_pkg::STATUS_W-1:0] status;
  logic [nls_pkg::LEN_W-1:0]    length;

  // predictor state
  scan_t       scan = SC_IDLE;
  bit          got_digit = 1'b0;
  int unsigned taken = 0;

  lit_result_t pending_results[$];
  int          mismatches = 0;
  int          results_checked = 0;
  int          saturated = 0;
  int          scanned = 0;
  int          literals = 0;
  int          idle_pct = 8;
  int          stall_pct = 80;
  bit          fresh;

  dir_row_t dir_rows[25] = '{
    '{1'b0, nls_pkg::CH_UC_A,  1'b0, nls_pkg::ST_NUMBER,   8'd0},  // ignored while idle
    '{1'b1, "z",               1'b1, nls_pkg::ST_BAD_DEC,  8'd0},
    '{1'b1, 8'hFF,             1'b1, nls_pkg::ST_BAD_DEC,  8'd0},
    '{1'b1, nls_pkg::CH_ZERO,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_UC_X,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_LC_F,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_UNDER, 1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, 8'h00,             1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b1, nls_pkg::CH_ZERO,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_LC_B,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, "2",               1'b1, nls_pkg::ST_BAD_BIN,  8'd2},
    '{1'b1, nls_pkg::CH_NINE,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b1, nls_pkg::CH_ZERO,  1'b0, nls_pkg::ST_NUMBER,   8'd0},  // restart drops the open literal
    '{1'b0, nls_pkg::CH_UNDER, 1'b0, nls_pkg::ST_NUMBER,   8'd0},  // underscore after lone zero
    '{1'b1, nls_pkg::CH_ONE,   1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_UC_E,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_MINUS, 1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_LC_X,  1'b1, nls_pkg::ST_BAD_EXP,  8'd3},
    '{1'b1, nls_pkg::CH_ZERO,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_LC_X,  1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, "g",               1'b1, nls_pkg::ST_BAD_HEX,  8'd2},
    '{1'b1, "5",               1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_DOT,   1'b0, nls_pkg::ST_NUMBER,   8'd0},
    '{1'b0, nls_pkg::CH_LC_E,  1'b1, nls_pkg::ST_BAD_FRAC, 8'd2},
    '{1'b0, 8'hFF,             1'b0, nls_pkg::ST_NUMBER,   8'd0}   // ignored after a result
  };

  numeric_literal_scanner #(.MAX_LENGTH(LIT_MAX)) DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .start_new    (start_new),
    .char_code    (char_code),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .length       (length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit is_digit(input logic [nls_pkg::CHAR_W-1:0] c);
    return c >= nls_pkg::CH_ZERO && c <= nls_pkg::CH_NINE;
  endfunction

  function automatic void count_char();
    if (taken < LIT_MAX) taken++;
  endfunction

  // Advances the scanner by one character; returns 1 when the literal ends here.
  function automatic bit scan_char(input bit s, input logic [nls_pkg::CHAR_W-1:0] c,
                                   output logic [nls_pkg::STATUS_W-1:0] st,
                                   output logic [nls_pkg::LEN_W-1:0] len);
    bit fin, stop, ok, us;
    fin = 1'b0;
    stop = 1'b0;
    st = nls_pkg::ST_NUMBER;
    len = '0;
    us = (c == nls_pkg::CH_UNDER);
    if (s) begin
      scan = SC_OPEN;
      got_digit = 1'b0;
      taken = 0;
    end
    if (scan == SC_IDLE) return 1'b0;
    while (!stop) begin
      case (scan)
        SC_OPEN: begin
          if (c == nls_pkg::CH_ZERO) begin
            count_char(); scan = SC_LEAD0; stop = 1'b1;
          end else begin
            scan = SC_WHOLE; got_digit = 1'b0;
          end
        end
        SC_LEAD0: begin
          if (c == nls_pkg::CH_LC_X || c == nls_pkg::CH_UC_X) begin
            count_char(); scan = SC_HEX; got_digit = 1'b0; stop = 1'b1;
          end else if (c == nls_pkg::CH_LC_B || c == nls_pkg::CH_UC_B) begin
            count_char(); scan = SC_BIN; got_digit = 1'b0; stop = 1'b1;
          end else if (is_digit(c)) begin
            scan = SC_WHOLE; got_digit = 1'b0;
          end else begin
            scan = SC_POST_WHOLE;
          end
        end
        SC_WHOLE, SC_FRAC, SC_EXP: begin
          if (is_digit(c) || us) begin
            if (!us) got_digit = 1'b1;
            count_char(); stop = 1'b1;
          end else if (!got_digit) begin
            st = (scan == SC_WHOLE) ? nls_pkg::ST_BAD_DEC :
                 (scan == SC_FRAC) ? nls_pkg::ST_BAD_FRAC : nls_pkg::ST_BAD_EXP;
            fin = 1'b1; stop = 1'b1;
          end else if (scan == SC_WHOLE) begin
            scan = SC_POST_WHOLE;
          end else if (scan == SC_FRAC) begin
            scan = SC_POST_FRAC;
          end else begin
            fin = 1'b1; stop = 1'b1;
          end
        end
        SC_POST_WHOLE: begin
          if (c == nls_pkg::CH_DOT) begin
            count_char(); scan = SC_FRAC; got_digit = 1'b0; stop = 1'b1;
          end else begin
            scan = SC_POST_FRAC;
          end
        end
        SC_POST_FRAC: begin
          if (c == nls_pkg::CH_LC_E || c == nls_pkg::CH_UC_E) begin
            count_char(); scan = SC_EXP_SGN; got_digit = 1'b0; stop = 1'b1;
          end else begin
            fin = 1'b1; stop = 1'b1;
          end
        end
        SC_EXP_SGN: begin
          if (c == nls_pkg::CH_PLUS || c == nls_pkg::CH_MINUS) begin
            count_char(); stop = 1'b1;
          end
          scan = SC_EXP;
        end
        SC_HEX, SC_BIN: begin
          if (scan == SC_HEX)
            ok = is_digit(c) || (c >= nls_pkg::CH_LC_A && c <= nls_pkg::CH_LC_F)
                 || (c >= nls_pkg::CH_UC_A && c <= nls_pkg::CH_UC_F);
          else
            ok = (c == nls_pkg::CH_ZERO || c == nls_pkg::CH_ONE);
          if (ok || us) begin
            if (!us) got_digit = 1'b1;
            count_char(); stop = 1'b1;
          end else begin
            st = got_digit ? nls_pkg::ST_NUMBER :
                 (scan == SC_HEX) ? nls_pkg::ST_BAD_HEX : nls_pkg::ST_BAD_BIN;
            fin = 1'b1; stop = 1'b1;
          end
        end
        default: begin
          scan = SC_IDLE; stop = 1'b1;
        end
      endcase
    end
    if (!fin) return 1'b0;
    len = (taken > 255) ? 8'd255 : taken[7:0];
    scan = SC_IDLE;
    got_digit = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_char(input bit s, input logic [nls_pkg::CHAR_W-1:0] c, input bit typed,
                           input logic [nls_pkg::STATUS_W-1:0] t_st,
                           input logic [nls_pkg::LEN_W-1:0] t_len);
    logic [nls_pkg::STATUS_W-1:0] st;
    logic [nls_pkg::LEN_W-1:0]    len;
    while ($urandom_range(0, 99) < idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    start_new <= s;
    char_code <= c;
    do @(posedge clk); while (char_stall);
    scanned++;
    if (scan_char(s, c, st, len))
      pending_results.push_back(typed ? lit_result_t'{t_st, t_len} : lit_result_t'{st, len});
    @(negedge clk);
  endtask

  task automatic put(input logic [nls_pkg::CHAR_W-1:0] c);
    send_char(fresh, c, 1'b0, nls_pkg::ST_NUMBER, '0);
    fresh = 1'b0;
  endtask

  // digits of the given radix with some underscores and an occasional stray byte
  task automatic emit_group(input int n, input int radix);
    int v;
    logic [nls_pkg::CHAR_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(0, 39);
      if (v < 6) c = nls_pkg::CH_UNDER;
      else if (v == 6) c = char_t'($urandom_range(0, 255));
      else if (radix == 2) c = char_t'(nls_pkg::CH_ZERO + (v & 1));
      else if (radix == 10) c = char_t'(nls_pkg::CH_ZERO + (v % 10));
      else begin
        v = v % 22;
        c = (v < 10) ? char_t'(nls_pkg::CH_ZERO + v) :
            (v < 16) ? char_t'(nls_pkg::CH_LC_A + (v - 10)) :
                       char_t'(nls_pkg::CH_UC_A + (v - 16));
      end
      put(c);
    end
  endtask

  task automatic emit_literal();
    int kind;
    fresh = 1'b1;
    literals++;
    kind = (literals % 100 == 50) ? 11 : $urandom_range(0, 10);
    case (kind)
      0, 1: begin
        put(nls_pkg::CH_ZERO);
        put($urandom_range(0, 1) ? nls_pkg::CH_LC_X : nls_pkg::CH_UC_X);
        emit_group($urandom_range(0, 6), 16);
      end
      2: begin
        put(nls_pkg::CH_ZERO);
        put($urandom_range(0, 1) ? nls_pkg::CH_LC_B : nls_pkg::CH_UC_B);
        emit_group($urandom_range(0, 6), 2);
      end
      9: begin
        for (int i = $urandom_range(1, 4); i > 0; i--) put(char_t'($urandom_range(0, 255)));
      end
      10: begin
        put(nls_pkg::CH_ZERO);
        case ($urandom_range(0, 3))
          0: put(nls_pkg::CH_UNDER);
          1: put(nls_pkg::CH_DOT);
          2: put(nls_pkg::CH_LC_E);
          default: put(char_t'($urandom_range(0, 255)));
        endcase
        emit_group($urandom_range(0, 3), 10);
      end
      11: begin
        // long literal of plain digits: count can reach saturation
        put(nls_pkg::CH_ONE);
        for (int i = $urandom_range(250, 300); i > 0; i--)
          put(char_t'(nls_pkg::CH_ZERO + (i % 10)));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) put(nls_pkg::CH_ZERO);
        emit_group($urandom_range(0, 5), 10);
        if ($urandom_range(0, 1)) begin
          put(nls_pkg::CH_DOT);
          emit_group($urandom_range(0, 4), 10);
        end
        if ($urandom_range(0, 1)) begin
          put($urandom_range(0, 1) ? nls_pkg::CH_LC_E : nls_pkg::CH_UC_E);
          case ($urandom_range(0, 2))
            0: put(nls_pkg::CH_PLUS);
            1: put(nls_pkg::CH_MINUS);
            default: ;
          endcase
          emit_group($urandom_range(0, 3), 10);
        end
      end
    endcase
    // sometimes no terminator, so the open literal may be dropped by the next start
    if ($urandom_range(0, 7) != 0) begin
      case ($urandom_range(0, 4))
        0: put(8'h00);
        1: put(" ");
        2: put(";");
        3: put(")");
        default: put(char_t'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      for (int i = $urandom_range(1, 3); i > 0; i--)
        send_char(1'b0, char_t'($urandom_range(0, 255)), 1'b0, nls_pkg::ST_NUMBER, '0);
  endtask

  always @(negedge clk) result_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d length=%0d", status, length));
      end else begin
        if (status !== pending_results[0].status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    status, pending_results[0].status));
        if (length !== pending_results[0].length)
          report_mismatch($sformatf("length %0d, expected %0d",
                                    length, pending_results[0].length));
        if (pending_results[0].length == 8'd255) saturated++;
        void'(pending_results.pop_front());
        results_checked++;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_char(dir_rows[i].s, dir_rows[i].c, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].len);

    while (scanned < 1350) begin
      if (scanned < 450) begin
        idle_pct = 8;
        stall_pct = 80;
      end else if (scanned < 900) begin
        idle_pct = 80;
        stall_pct = 8;
      end else begin
        idle_pct = 0;
        stall_pct = 0;
      end
      emit_literal();
    end
    char_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Scanned %0d characters over %0d random literals plus the directed table.",
             scanned, literals);
    $display("Checked %0d results, %0d of them at saturated length.", results_checked, saturated);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
